FILE: hw/rtl/tbws_pkg.sv
// Package for the cassette waveform sequencer.
// Holds stage and leader phase codes, register indexes, sizes and widths.
// No dependencies.
package tbws_pkg;

  localparam int CHUNK_BYTES    = 16384;
  localparam int MAX_PAUSE      = 8192;
  localparam int HDR_BYTE_COUNT = 18;

  localparam int CHUNK_W = $clog2(CHUNK_BYTES + 1);
  localparam int HPOS_W  = 5;
  localparam int PAUSE_W = 9;
  localparam int DUR_W   = 15;
  localparam int LEN_W   = 24;
  localparam int HALF_W  = 12;
  localparam int LCNT_W  = 11;
  localparam int STAGE_W = 4;
  localparam int PHASE_W = 3;
  localparam int CFG_IDX_W = 4;

  localparam logic [PAUSE_W-1:0] HDR_PAUSE_MS = 9'd372;
  localparam logic [PAUSE_W-1:0] EXT_PAUSE_MS = 9'd186;

  localparam logic [STAGE_W-1:0] ST_HDR_LEAD  = 4'd0;
  localparam logic [STAGE_W-1:0] ST_HDR_BYTES = 4'd1;
  localparam logic [STAGE_W-1:0] ST_HDR_PAUSE = 4'd2;
  localparam logic [STAGE_W-1:0] ST_SYS_LEAD  = 4'd3;
  localparam logic [STAGE_W-1:0] ST_SYS_BYTES = 4'd4;
  localparam logic [STAGE_W-1:0] ST_PRG_LEAD  = 4'd5;
  localparam logic [STAGE_W-1:0] ST_PRG_BYTES = 4'd6;
  localparam logic [STAGE_W-1:0] ST_VAR_LEAD  = 4'd7;
  localparam logic [STAGE_W-1:0] ST_VAR_BYTES = 4'd8;
  localparam logic [STAGE_W-1:0] ST_EXT_PAUSE = 4'd9;
  localparam logic [STAGE_W-1:0] ST_EXT_LEAD  = 4'd10;
  localparam logic [STAGE_W-1:0] ST_EXT_BYTES = 4'd11;
  localparam logic [STAGE_W-1:0] ST_DONE      = 4'd12;

  localparam logic [PHASE_W-1:0] PH_PRE      = 3'd0;
  localparam logic [PHASE_W-1:0] PH_BITS     = 3'd1;
  localparam logic [PHASE_W-1:0] PH_POST     = 3'd2;
  localparam logic [PHASE_W-1:0] PH_GAP      = 3'd3;
  localparam logic [PHASE_W-1:0] PH_COMPLETE = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_SYS_LEN   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRG_LEN   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VAR_LEN   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_EXT_LEN   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SHORT     = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LONG      = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GAP       = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_LEAD_CNT  = 4'd7;

  // where the section chain starts looking after a section or pause ends
  typedef enum logic [2:0] {
    CH_SYS,
    CH_PRG,
    CH_VAR,
    CH_EXT,
    CH_DONE
  } chain_t;

endpackage

FILE: hw/rtl/tape_block_waveform_sequencer_core.sv
// Cassette waveform sequencer top level: config registers, sequencer state,
// combinational step logic and the result register.
// Depends on tbws_pkg.
//
// Usage: each item on the input channel (in_valid / in_stall) is a request.
// req_type 0 starts a new tape, req_type 1 asks for the next half-period.
// stream_byte / stream_valid carry the next unread byte of the file; the
// result's byte_taken tells the sender whether that byte was consumed.
// Every request gives exactly one result item on the output channel
// (out_valid / out_stall): duration in us for a tone, in ms with is_pause
// for a pause piece, 0 when only the stage moved; finished and stage_code
// describe the stage after the step.
// The result is registered: it is in the output register the cycle after
// the request is accepted. One request per cycle is sustained while the
// receiver does not stall. in_stall is high only while a result waits and
// the receiver stalls. Configuration writes (cfg_valid / cfg_ready, always
// ready) are for the user to make between tapes; the block itself does not
// enforce it. Reset loads the default timings, zero section lengths and the
// done stage; no result is pending after reset.
module tape_block_waveform_sequencer_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            req_type,
  input  logic [7:0]                      stream_byte,
  input  logic                            stream_valid,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [tbws_pkg::DUR_W-1:0]      duration,
  output logic                            is_pause,
  output logic                            byte_taken,
  output logic                            finished,
  output logic [tbws_pkg::STAGE_W-1:0]    stage_code,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tbws_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tbws_pkg::LEN_W-1:0]      cfg_data
);
  import tbws_pkg::*;

  // configuration
  logic [LEN_W-1:0]  sys_length, program_length, variables_length, extra_length;
  logic [HALF_W-1:0] short_half_us, long_half_us, gap_us;
  logic [LCNT_W-1:0] leader_count;

  // sequencer state
  logic [STAGE_W-1:0] stage, stage_next;
  logic [PHASE_W-1:0] leader_phase, leader_phase_next;
  logic [LCNT_W-1:0]  leader_left, leader_left_next;
  logic               half_flag, half_flag_next;
  logic               byte_loaded, byte_loaded_next;
  logic [7:0]         shift_byte, shift_byte_next;
  logic [2:0]         bit_position, bit_position_next;
  logic [HPOS_W-1:0]  header_position, header_position_next;
  logic [1:0]         tail_zero_count, tail_zero_count_next;
  logic [LEN_W-1:0]   section_left, section_left_next;
  logic [CHUNK_W-1:0] chunk_left, chunk_left_next;
  logic [PAUSE_W-1:0] pause_left, pause_left_next;

  logic [DUR_W-1:0]   o_dur;
  logic               o_pause, o_taken;
  logic               do_chain;
  chain_t             chain_from;
  logic               in_accept;
  logic [DUR_W-1:0]   piece;
  logic               skip_send;
  logic               ok;
  logic               bit_one;

  assign in_stall  = out_valid & out_stall;
  assign in_accept = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sys_length       <= '0;
      program_length   <= '0;
      variables_length <= '0;
      extra_length     <= '0;
      short_half_us    <= 12'd204;
      long_half_us     <= 12'd408;
      gap_us           <= 12'd612;
      leader_count     <= 11'd1500;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SYS_LEN:  sys_length       <= cfg_data;
        REG_PRG_LEN:  program_length   <= cfg_data;
        REG_VAR_LEN:  variables_length <= cfg_data;
        REG_EXT_LEN:  extra_length     <= cfg_data;
        REG_SHORT:    short_half_us    <= cfg_data[HALF_W-1:0];
        REG_LONG:     long_half_us     <= cfg_data[HALF_W-1:0];
        REG_GAP:      gap_us           <= cfg_data[HALF_W-1:0];
        REG_LEAD_CNT: leader_count     <= cfg_data[LCNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    stage_next           = stage;
    leader_phase_next    = leader_phase;
    leader_left_next     = leader_left;
    half_flag_next       = half_flag;
    byte_loaded_next     = byte_loaded;
    shift_byte_next      = shift_byte;
    bit_position_next    = bit_position;
    header_position_next = header_position;
    tail_zero_count_next = tail_zero_count;
    section_left_next    = section_left;
    chunk_left_next      = chunk_left;
    pause_left_next      = pause_left;
    o_dur      = '0;
    o_pause    = 1'b0;
    o_taken    = 1'b0;
    do_chain   = 1'b0;
    chain_from = CH_DONE;
    piece      = '0;
    skip_send  = 1'b0;
    ok         = 1'b0;
    bit_one    = 1'b0;

    if (!req_type) begin
      header_position_next = '0;
      tail_zero_count_next = '0;
      section_left_next    = '0;
      chunk_left_next      = '0;
      pause_left_next      = '0;
      shift_byte_next      = '0;
      stage_next           = ST_HDR_LEAD;
      leader_phase_next    = PH_PRE;
      leader_left_next     = leader_count;
      half_flag_next       = 1'b0;
      byte_loaded_next     = 1'b0;
      bit_position_next    = '0;
    end else begin
      case (stage)
        ST_HDR_LEAD, ST_SYS_LEAD, ST_PRG_LEAD, ST_VAR_LEAD, ST_EXT_LEAD: begin
          case (leader_phase)
            PH_PRE: begin
              o_dur = DUR_W'(short_half_us);
              leader_phase_next = PH_BITS;
            end
            PH_BITS: begin
              o_dur = DUR_W'(short_half_us);
              half_flag_next = ~half_flag;
              if (half_flag) begin
                leader_left_next = leader_left - 1'b1;
                if (leader_left_next == '0) begin
                  leader_phase_next = PH_POST;
                end
              end
            end
            PH_POST: begin
              o_dur = DUR_W'(short_half_us);
              leader_phase_next = PH_GAP;
            end
            PH_GAP: begin
              o_dur = DUR_W'(gap_us);
              leader_phase_next = PH_COMPLETE;
              half_flag_next = 1'b0;
              stage_next = stage + 1'b1;
            end
            default: begin
              stage_next = stage + 1'b1;
            end
          endcase
        end
        ST_HDR_BYTES: begin
          if (!byte_loaded) begin
            if (header_position < HPOS_W'(HDR_BYTE_COUNT)) begin
              shift_byte_next = stream_valid ? stream_byte : 8'd0;
              o_taken = stream_valid;
              header_position_next = header_position + 1'b1;
            end else if (tail_zero_count < 2'd2) begin
              tail_zero_count_next = tail_zero_count + 1'b1;
              shift_byte_next = 8'd0;
            end else begin
              pause_left_next = HDR_PAUSE_MS;
              stage_next = ST_HDR_PAUSE;
              skip_send = 1'b1;
            end
            if (!skip_send) begin
              byte_loaded_next  = 1'b1;
              bit_position_next = '0;
              half_flag_next    = 1'b0;
            end
          end
          if (!skip_send) begin
            bit_one = shift_byte_next[bit_position_next];
            o_dur = bit_one ? DUR_W'(long_half_us) : DUR_W'(short_half_us);
            half_flag_next = ~half_flag_next;
            if (!half_flag_next) begin
              bit_position_next = bit_position_next + 1'b1;
              if (bit_position_next == '0) begin
                byte_loaded_next = 1'b0;
              end
            end
          end
        end
        ST_SYS_BYTES, ST_PRG_BYTES, ST_VAR_BYTES, ST_EXT_BYTES: begin
          if (!byte_loaded) begin
            if (section_left != '0) begin
              if (chunk_left == '0) begin
                chunk_left_next = (section_left > LEN_W'(CHUNK_BYTES)) ?
                                  CHUNK_W'(CHUNK_BYTES) : section_left[CHUNK_W-1:0];
              end
              if (stream_valid) begin
                shift_byte_next = stream_byte;
                o_taken = 1'b1;
                ok = 1'b1;
              end
            end
            if (!ok) begin
              do_chain  = 1'b1;
              skip_send = 1'b1;
            end else begin
              byte_loaded_next  = 1'b1;
              bit_position_next = '0;
              half_flag_next    = 1'b0;
            end
          end
          if (!skip_send) begin
            bit_one = shift_byte_next[bit_position_next];
            o_dur = bit_one ? DUR_W'(long_half_us) : DUR_W'(short_half_us);
            half_flag_next = ~half_flag_next;
            if (!half_flag_next) begin
              bit_position_next = bit_position_next + 1'b1;
              if (bit_position_next == '0) begin
                if (chunk_left_next != '0) chunk_left_next = chunk_left_next - 1'b1;
                if (section_left != '0) section_left_next = section_left - 1'b1;
                byte_loaded_next = 1'b0;
                if (chunk_left_next == '0 && section_left_next != '0) begin
                  stage_next        = stage - 1'b1;
                  leader_phase_next = PH_PRE;
                  leader_left_next  = leader_count;
                  half_flag_next    = 1'b0;
                  bit_position_next = '0;
                end else if (section_left_next == '0) begin
                  do_chain = 1'b1;
                end
              end
            end
          end
        end
        ST_HDR_PAUSE, ST_EXT_PAUSE: begin
          if (pause_left == '0) begin
            if (stage == ST_HDR_PAUSE) begin
              do_chain   = 1'b1;
              chain_from = CH_SYS;
            end else if (extra_length != '0) begin
              stage_next        = ST_EXT_LEAD;
              section_left_next = extra_length;
              chunk_left_next   = '0;
              leader_phase_next = PH_PRE;
              leader_left_next  = leader_count;
              half_flag_next    = 1'b0;
              byte_loaded_next  = 1'b0;
              bit_position_next = '0;
            end else begin
              stage_next = ST_DONE;
            end
          end else begin
            piece = (DUR_W'(pause_left) > DUR_W'(MAX_PAUSE)) ?
                    DUR_W'(MAX_PAUSE) : DUR_W'(pause_left);
            o_dur   = piece;
            o_pause = 1'b1;
            pause_left_next = PAUSE_W'(DUR_W'(pause_left) - piece);
          end
        end
        default: ;
      endcase
    end

    if (do_chain) begin
      if (stage != ST_HDR_PAUSE) begin
        case (stage)
          ST_SYS_BYTES: chain_from = CH_PRG;
          ST_PRG_BYTES: chain_from = CH_VAR;
          ST_VAR_BYTES: chain_from = CH_EXT;
          default:      chain_from = CH_DONE;
        endcase
      end
      if (chain_from == CH_SYS && sys_length != '0) begin
        stage_next        = ST_SYS_LEAD;
        section_left_next = sys_length;
      end else if ((chain_from == CH_SYS || chain_from == CH_PRG) &&
                   program_length != '0) begin
        stage_next        = ST_PRG_LEAD;
        section_left_next = program_length;
      end else if ((chain_from == CH_SYS || chain_from == CH_PRG ||
                    chain_from == CH_VAR) && variables_length != '0) begin
        stage_next        = ST_VAR_LEAD;
        section_left_next = variables_length;
      end else if (chain_from != CH_DONE && extra_length != '0) begin
        stage_next      = ST_EXT_PAUSE;
        pause_left_next = EXT_PAUSE_MS;
      end else begin
        stage_next = ST_DONE;
      end
      if (stage_next == ST_SYS_LEAD || stage_next == ST_PRG_LEAD ||
          stage_next == ST_VAR_LEAD) begin
        chunk_left_next   = '0;
        leader_phase_next = PH_PRE;
        leader_left_next  = leader_count;
        half_flag_next    = 1'b0;
        byte_loaded_next  = 1'b0;
        bit_position_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage           <= ST_DONE;
      leader_phase    <= PH_COMPLETE;
      leader_left     <= '0;
      half_flag       <= 1'b0;
      byte_loaded     <= 1'b0;
      shift_byte      <= '0;
      bit_position    <= '0;
      header_position <= '0;
      tail_zero_count <= '0;
      section_left    <= '0;
      chunk_left      <= '0;
      pause_left      <= '0;
    end else if (in_accept) begin
      stage           <= stage_next;
      leader_phase    <= leader_phase_next;
      leader_left     <= leader_left_next;
      half_flag       <= half_flag_next;
      byte_loaded     <= byte_loaded_next;
      shift_byte      <= shift_byte_next;
      bit_position    <= bit_position_next;
      header_position <= header_position_next;
      tail_zero_count <= tail_zero_count_next;
      section_left    <= section_left_next;
      chunk_left      <= chunk_left_next;
      pause_left      <= pause_left_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      duration   <= o_dur;
      is_pause   <= o_pause;
      byte_taken <= o_taken;
      finished   <= (stage_next >= ST_DONE);
      stage_code <= stage_next;
    end
  end

  a_start_result: assert property (@(posedge clk) disable iff (rst)
    in_accept && !req_type |=> out_valid && stage_code == ST_HDR_LEAD &&
      duration == '0 && !finished)
    else $error("start request gave a wrong result");

  a_taken_in_bytes: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_taken |-> !is_pause &&
      (stage_code == ST_HDR_BYTES || stage_code == ST_SYS_BYTES ||
       stage_code == ST_PRG_BYTES || stage_code == ST_VAR_BYTES ||
       stage_code == ST_EXT_BYTES))
    else $error("byte taken outside a byte stage");

  a_finished_done: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> finished == (stage_code == ST_DONE))
    else $error("finished flag disagrees with stage");

  a_pause_stage: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_pause |-> duration != '0 &&
      (stage_code == ST_HDR_PAUSE || stage_code == ST_EXT_PAUSE))
    else $error("pause piece outside a pause stage");

endmodule
